### hdl/isort_pkg.sv
package isort_pkg;

  localparam int unsigned ISORT_DATA_W   = 32;
  localparam int unsigned ISORT_CAPACITY = 64;

endpackage

### hdl/isort_ram.sv
module isort_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/insertion_sorter.sv
// insertion_sorter: collects a set of signed 32-bit values and returns it sorted.
//
// input channel (in_valid_i / in_ready_o): one sample_value_i per request,
//   set_end_i marks the last value of the set. an unmarked request produces
//   nothing. values past CAPACITY are dropped and flagged.
// output channel (out_valid_o / out_ready_i): after the marked request the
//   set comes out in order, final_result_o on the last value, overflow_seen_o
//   on every value of a set that lost items.
// cfg_we_i / cfg_wdata_i set the order (1 = descending); it is sampled when
//   the marked request is taken.
// for a set of n values: n input requests, then a stable insertion sort
//   in the value ram, one ram read and one ram write per cycle: each key is
//   loaded, compared and placed, each entry it passes shifted up one slot,
//   then the results go out through the single read port and output register.
// in_ready_o is high only between sets; the next set starts once the final
//   result is taken. a stalled receiver just holds the current result.
// reset clears the count, the drop flag, the order bit and the controller;
//   the ram is not cleared, only entries written in the current set are read.
module insertion_sorter
  import isort_pkg::*;
#(
  parameter int unsigned CAPACITY = ISORT_CAPACITY
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [ISORT_DATA_W-1:0] sample_value_i,
  input  logic                           set_end_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [ISORT_DATA_W-1:0] sorted_value_o,
  output logic                           final_result_o,
  output logic                           overflow_seen_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_KEY   = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_PLACE = 3'd4;
  localparam logic [2:0] S_ORD   = 3'd5;
  localparam logic [2:0] S_OLOAD = 3'd6;
  localparam logic [2:0] S_OHOLD = 3'd7;

  logic [2:0] state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic dropped_q, dropped_d;
  logic cfg_desc_q;
  logic desc_q, desc_d;
  logic [CW-1:0] i_q, i_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [CW-1:0] k_q, k_d;
  logic signed [ISORT_DATA_W-1:0] key_q, key_d;
  logic signed [ISORT_DATA_W-1:0] out_val_q, out_val_d;
  logic fin_q, fin_d;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [ISORT_DATA_W-1:0] ram_wdata;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;
  logic [ISORT_DATA_W-1:0] ram_rdata;
  logic signed [ISORT_DATA_W-1:0] prev;
  logic move;
  logic in_take;
  logic has_room;

  isort_ram #(
    .WIDTH(ISORT_DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign prev     = $signed(ram_rdata);
  assign move     = desc_q ? (prev < key_q) : (prev > key_q);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_take  = in_valid_i && in_ready_o;
  assign has_room = (count_q < CW'(CAPACITY));

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    dropped_d = dropped_q;
    desc_d    = desc_q;
    i_d       = i_q;
    pos_d     = pos_q;
    k_d       = k_q;
    key_d     = key_q;
    out_val_d = out_val_q;
    fin_d     = fin_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = key_q;
    ram_re    = 1'b0;
    ram_raddr = pos_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          if (has_room) begin
            ram_we    = 1'b1;
            ram_waddr = count_q[AW-1:0];
            ram_wdata = sample_value_i;
            count_d   = count_q + 1'b1;
          end else begin
            dropped_d = 1'b1;
          end
          if (set_end_i) begin
            desc_d = cfg_desc_q;
            i_d    = CW'(1);
            k_d    = '0;
            // a set of one needs no sorting
            if (count_d > CW'(1)) begin
              state_d = S_KEY;
            end else begin
              state_d = S_ORD;
            end
          end
        end
      end
      S_KEY: begin
        ram_re    = 1'b1;
        ram_raddr = i_q[AW-1:0];
        pos_d     = i_q[AW-1:0];
        state_d   = S_LOAD;
      end
      S_LOAD: begin
        key_d     = $signed(ram_rdata);
        ram_re    = 1'b1;
        ram_raddr = pos_q - 1'b1;
        state_d   = S_CMP;
      end
      S_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        if (move) begin
          // shift prev up one slot, keep walking down
          ram_wdata = prev;
          pos_d     = pos_q - 1'b1;
          if (pos_q == AW'(1)) begin
            state_d = S_PLACE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = pos_q - AW'(2);
          end
        end else begin
          ram_wdata = key_q;
          if (i_q + 1'b1 < count_q) begin
            i_d     = i_q + 1'b1;
            state_d = S_KEY;
          end else begin
            state_d = S_ORD;
          end
        end
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = key_q;
        if (i_q + 1'b1 < count_q) begin
          i_d     = i_q + 1'b1;
          state_d = S_KEY;
        end else begin
          state_d = S_ORD;
        end
      end
      S_ORD: begin
        ram_re    = 1'b1;
        ram_raddr = k_q[AW-1:0];
        state_d   = S_OLOAD;
      end
      S_OLOAD: begin
        out_val_d = $signed(ram_rdata);
        fin_d     = (k_q + 1'b1 == count_q);
        state_d   = S_OHOLD;
      end
      S_OHOLD: begin
        if (out_ready_i) begin
          if (fin_q) begin
            count_d   = '0;
            dropped_d = 1'b0;
            state_d   = S_IDLE;
          end else begin
            // fetch the next result while this one leaves
            k_d       = k_q + 1'b1;
            ram_re    = 1'b1;
            ram_raddr = k_d[AW-1:0];
            state_d   = S_OLOAD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      dropped_q  <= 1'b0;
      cfg_desc_q <= 1'b0;
      desc_q     <= 1'b0;
      i_q        <= '0;
      pos_q      <= '0;
      k_q        <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      desc_q    <= desc_d;
      i_q       <= i_d;
      pos_q     <= pos_d;
      k_q       <= k_d;
      if (cfg_we_i) begin
        cfg_desc_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    out_val_q <= out_val_d;
    fin_q     <= fin_d;
  end

  assign out_valid_o     = (state_q == S_OHOLD);
  assign sorted_value_o  = out_val_q;
  assign final_result_o  = fin_q;
  assign overflow_seen_o = dropped_q;

  // sorting and output never touch entries beyond the stored count
  a_sort_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q != S_IDLE) |-> (CW'(ram_waddr) < count_q))
    else $error("ram write outside the stored set");

  a_cmp_pos_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (pos_q != '0))
    else $error("compare step at slot zero");

  a_no_accept_while_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  a_clear_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && final_result_o) |=> (count_q == '0 && !dropped_q))
    else $error("set state not cleared after final result");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("item count exceeds capacity");

endmodule

### sim/tb_insertion_sorter.sv
`timescale 1ns / 1ps

module tb_insertion_sorter;
  import isort_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam logic signed [ISORT_DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [ISORT_DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [ISORT_DATA_W-1:0] value;
    logic                           last;
    logic                           ovf;
  } sorted_result_t;

  logic                           clk_i           = 1'b0;
  logic                           rst_ni          = 1'b0;
  logic                           cfg_we_i        = 1'b0;
  logic                           cfg_wdata_i     = 1'b0;
  logic                           in_valid_i      = 1'b0;
  logic                           in_ready_o;
  logic signed [ISORT_DATA_W-1:0] sample_value_i  = '0;
  logic                           set_end_i       = 1'b0;
  logic                           out_valid_o;
  logic                           out_ready_i     = 1'b0;
  logic signed [ISORT_DATA_W-1:0] sorted_value_o;
  logic                           final_result_o;
  logic                           overflow_seen_o;

  // shadow copy of the sorter state
  logic signed [ISORT_DATA_W-1:0] set_store [ISORT_CAPACITY];
  int                             set_count        = 0;
  logic                           set_dropped      = 1'b0;
  logic                           order_desc_model = 1'b0;
  sorted_result_t                 sorted_expect_q [$];

  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int items_sent      = 0;
  int sets_sent       = 0;
  int overflow_sets   = 0;
  int order_writes    = 0;
  int results_checked = 0;
  int error_count     = 0;
  int stall_cycles    = 0;

  insertion_sorter i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_value_i  (sample_value_i),
    .set_end_i       (set_end_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .sorted_value_o  (sorted_value_o),
    .final_result_o  (final_result_o),
    .overflow_seen_o (overflow_seen_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // store each sample; stable insertion sort of the collected set on the marked request
  function automatic void predict_sample(input logic signed [ISORT_DATA_W-1:0] v,
                                         input logic e);
    int                             i;
    int                             pos;
    logic signed [ISORT_DATA_W-1:0] key;
    sorted_result_t                 r;
    if (set_count < ISORT_CAPACITY) begin
      set_store[set_count] = v;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!e) return;
    for (i = 1; i < set_count; i++) begin
      key = set_store[i];
      pos = i;
      while (pos > 0 && (order_desc_model ? (set_store[pos-1] < key)
                                          : (set_store[pos-1] > key))) begin
        set_store[pos] = set_store[pos-1];
        pos--;
      end
      set_store[pos] = key;
    end
    for (i = 0; i < set_count; i++) begin
      r.value = set_store[i];
      r.last  = (i == set_count - 1);
      r.ovf   = set_dropped;
      sorted_expect_q.push_back(r);
    end
    sets_sent++;
    if (set_dropped) overflow_sets++;
    set_count   = 0;
    set_dropped = 1'b0;
  endfunction

  function automatic logic signed [ISORT_DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 15) begin
      case ($urandom_range(4))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return '0;
        3:       return -1;
        default: return 1;
      endcase
    end else if (r < 45) begin
      // narrow range so equal keys show up often
      return $signed($urandom_range(8)) - 4;
    end
    return $urandom;
  endfunction

  function automatic int pick_set_size();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(8, 1);
    if (r < 95) return $urandom_range(24, 9);
    return $urandom_range(68, 56);
  endfunction

  task automatic send_sample(input logic signed [ISORT_DATA_W-1:0] v, input logic e);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i     <= 1'b1;
    sample_value_i <= v;
    set_end_i      <= e;
    do @(posedge clk_i); while (!in_ready_o);
    predict_sample(v, e);
    items_sent++;
  endtask

  task automatic send_random_set(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      send_sample(pick_value(), k == n - 1);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sorted_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_order(input logic desc);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= desc;
    @(posedge clk_i);
    cfg_we_i         <= 1'b0;
    order_desc_model  = desc;
    order_writes++;
  endtask

  task automatic test_ascending_extremes();
    send_sample(VAL_MAX, 1'b0);
    send_sample(VAL_MIN, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(1, 1'b1);
    // one-entry set
    send_sample(VAL_MIN, 1'b1);
    send_sample(5, 1'b0);
    send_sample(-3, 1'b0);
    send_sample(5, 1'b0);
    send_sample(5, 1'b1);
  endtask

  task automatic test_descending_extremes();
    wait_drained();
    write_order(1'b1);
    send_sample(VAL_MIN, 1'b0);
    send_sample(VAL_MAX, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(0, 1'b0);
    send_sample(32'sh5555_5555, 1'b0);
    send_sample(32'shAAAA_AAAA, 1'b1);
    send_sample(7, 1'b0);
    send_sample(7, 1'b0);
    send_sample(VAL_MAX, 1'b1);
  endtask

  task automatic test_overflow();
    wait_drained();
    write_order(1'b1);
    // fills the store, then the marked request itself is dropped
    send_random_set(ISORT_CAPACITY + 1);
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct,
                                   input logic desc, input int target);
    int phase_items;
    int set_size;
    phase_items = 0;
    wait_drained();
    write_order(desc);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    while (phase_items < target) begin
      if ($urandom_range(7) == 0) wait_drained();
      set_size = pick_set_size();
      if (set_size > target - phase_items) set_size = target - phase_items;
      send_random_set(set_size);
      phase_items += set_size;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    sorted_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sorted_expect_q.size() == 0) begin
        $display("%0t: unexpected result: value %0d final %b overflow %b",
                 $realtime, sorted_value_o, final_result_o, overflow_seen_o);
        error_count++;
      end else begin
        want = sorted_expect_q.pop_front();
        results_checked++;
        if (sorted_value_o !== want.value) begin
          $display("%0t: sorted_value mismatch: expected %0d, got %0d",
                   $realtime, want.value, sorted_value_o);
          error_count++;
        end
        if (final_result_o !== want.last) begin
          $display("%0t: final_result mismatch: expected %b, got %b",
                   $realtime, want.last, final_result_o);
          error_count++;
        end
        if (overflow_seen_o !== want.ovf) begin
          $display("%0t: overflow_seen mismatch: expected %b, got %b",
                   $realtime, want.ovf, overflow_seen_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ascending_extremes();
    test_descending_extremes();
    test_overflow();
    test_random_phase(0, 0, 1'b1, 12);
    test_random_phase(47, 0, 1'b0, 12);
    test_random_phase(0, 47, 1'b1, 12);
    test_random_phase(18, 18, 1'($urandom_range(1)), 12);

    wait_drained();
    repeat (16) @(posedge clk_i);

    $display("sent %0d samples in %0d sets (%0d overflowing), %0d order writes",
             items_sent, sets_sent, overflow_sets, order_writes);
    $display("checked %0d sorted results, %0d errors, %0d still expected",
             results_checked, error_count, sorted_expect_q.size());
    if (error_count == 0 && sorted_expect_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
